/* rtl/iebm_pkg.sv */
// ----------------------------------------------------------------------------
// iebm_pkg: shared types and constants
// Command codes, bus sub-phases, status codes and the queued item record
// used by the front end and the bus engine of the EEPROM byte master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iebm_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int DEV_W = 7;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_CARD = 2'd1,
    STATUS_FAIL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    SP_IDLE = 4'd0,
    SP_ST0  = 4'd1,
    SP_ST1  = 4'd2,
    SP_ST2  = 4'd3,
    SP_ST3  = 4'd4,
    SP_WLO  = 4'd5,
    SP_WHI  = 4'd6,
    SP_ALO  = 4'd7,
    SP_AHI  = 4'd8,
    SP_RLO  = 4'd9,
    SP_RHI  = 4'd10,
    SP_NLO  = 4'd11,
    SP_NHI  = 4'd12,
    SP_P1   = 4'd13,
    SP_P2   = 4'd14,
    SP_P3   = 4'd15
  } sub_t;

  typedef enum logic [1:0] {
    STG_DEV  = 2'd0,
    STG_ADDR = 2'd1,
    STG_LAST = 2'd2,
    STG_RECV = 2'd3
  } stage_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] word_address;
    logic [BYTE_W-1:0] write_data;
    logic [BYTE_W-1:0] byte_count;
    logic              card_present;
    logic              sda_in;
  } item_t;

endpackage

`default_nettype wire

/* rtl/i2c_eeprom_byte_master.sv */
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master: serial EEPROM byte write and random read master
// Takes one bus bit-phase tick per input beat with the sampled SDA level and
// returns the SCL and SDA levels driven in that tick with transaction status.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------
//   input    | in        | in_valid/in_stall  | operation .. sda_in
//   result   | out       | out_valid/out_stall| scl_level .. status
//   config   | in        | cfg_valid/cfg_ready| cfg_data (device address)
//
// One tick enters and one result leaves per cycle unless the result stalls;
// a tick passes the item queue, then the sequencer's result register.
// Reset clears the queue, the sequencer state and the result valid flag.
// A stalled result holds the sequencer; the queue of QUEUE_DEPTH beats then
// fills and in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_eeprom_byte_master #(
  parameter int QUEUE_DEPTH = iebm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [iebm_pkg::DEV_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  operation,
  input  wire logic [iebm_pkg::BYTE_W-1:0] word_address,
  input  wire logic [iebm_pkg::BYTE_W-1:0] write_data,
  input  wire logic [iebm_pkg::BYTE_W-1:0] byte_count,
  input  wire logic                        card_present,
  input  wire logic                        sda_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             scl_level,
  output logic                             sda_release,
  output logic                             busy_res,
  output logic                             byte_valid,
  output logic [iebm_pkg::BYTE_W-1:0]      read_data,
  output logic                             done_res,
  output logic [1:0]                       status
);
  import iebm_pkg::*;

  localparam logic [DEV_W-1:0] DEV_RESET = 7'd80;

  logic [DEV_W-1:0] device_address;
  logic             q_valid;
  logic             q_pop;
  item_t            q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      device_address <= cfg_data;
    end
  end

  iebm_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .word_address (word_address),
    .write_data   (write_data),
    .byte_count   (byte_count),
    .card_present (card_present),
    .sda_in       (sda_in),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  iebm_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .device_address (device_address),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .scl_level      (scl_level),
    .sda_release    (sda_release),
    .busy_res       (busy_res),
    .byte_valid     (byte_valid),
    .read_data      (read_data),
    .done_res       (done_res),
    .status         (status)
  );

endmodule

`default_nettype wire

/* rtl/iebm_front.sv */
// ----------------------------------------------------------------------------
// iebm_front: command decode and item queue
// Accepts input beats, maps the operation code to a command and holds the
// decoded items in a small queue until the bus engine takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iebm_front #(
  parameter int QUEUE_DEPTH = iebm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                operation,
  input  wire logic [iebm_pkg::BYTE_W-1:0] word_address,
  input  wire logic [iebm_pkg::BYTE_W-1:0] write_data,
  input  wire logic [iebm_pkg::BYTE_W-1:0] byte_count,
  input  wire logic                      card_present,
  input  wire logic                      sda_in,
  output logic                           q_valid,
  output iebm_pkg::item_t                q_item,
  input  wire logic                      q_pop
);
  import iebm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  item_t            in_item;

  always_comb begin
    case (operation)
      OP_WRITE: in_item.cmd = CMD_WRITE;
      OP_READ:  in_item.cmd = CMD_READ;
      default:  in_item.cmd = CMD_TICK;
    endcase
    in_item.word_address = word_address;
    in_item.write_data   = write_data;
    in_item.byte_count   = byte_count;
    in_item.card_present = card_present;
    in_item.sda_in       = sda_in;
  end

  assign in_stall = (count == FULL_CNT);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/iebm_engine.sv */
// ----------------------------------------------------------------------------
// iebm_engine: bus sequencer and result register
// Steps the start, byte, acknowledge, receive and stop phases once per
// queued tick and registers one result beat per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iebm_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [iebm_pkg::DEV_W-1:0]  device_address,
  input  wire logic                        q_valid,
  input  wire iebm_pkg::item_t             q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             scl_level,
  output logic                             sda_release,
  output logic                             busy_res,
  output logic                             byte_valid,
  output logic [iebm_pkg::BYTE_W-1:0]      read_data,
  output logic                             done_res,
  output logic [1:0]                       status
);
  import iebm_pkg::*;

  stage_t            stage, stage_next;
  sub_t              sub, sub_next;
  logic [3:0]        bit_counter, bit_counter_next;
  logic [BYTE_W-1:0] shift_byte, shift_byte_next;
  logic [BYTE_W-1:0] current_address, current_address_next;
  logic [BYTE_W-1:0] bytes_left, bytes_left_next;
  logic [BYTE_W-1:0] held_data, held_data_next;
  logic              error_seen, error_seen_next;
  logic              is_read, is_read_next;

  logic              o_scl, o_sda, o_busy, o_valid, o_done;
  logic [BYTE_W-1:0] o_data;
  status_t           o_status;

  logic              emit_req, finish_req, fail_req, load_req;
  logic [BYTE_W-1:0] emit_data;
  stage_t            load_stage;
  logic [BYTE_W-1:0] dev_byte;
  logic              step_en;

  assign step_en  = !out_valid || !out_stall;
  assign q_pop    = q_valid && step_en;
  assign dev_byte = {device_address, 1'b0};

  always_comb begin
    stage_next           = stage;
    sub_next             = sub;
    bit_counter_next     = bit_counter;
    shift_byte_next      = shift_byte;
    current_address_next = current_address;
    bytes_left_next      = bytes_left;
    held_data_next       = held_data;
    error_seen_next      = error_seen;
    is_read_next         = is_read;
    o_scl      = 1'b1;
    o_sda      = 1'b1;
    o_busy     = (sub != SP_IDLE);
    o_valid    = 1'b0;
    o_data     = '0;
    o_done     = 1'b0;
    o_status   = STATUS_OK;
    emit_req   = 1'b0;
    finish_req = 1'b0;
    fail_req   = 1'b0;
    load_req   = 1'b0;
    emit_data  = shift_byte;
    load_stage = stage;

    case (sub)
      SP_IDLE: begin
        stage_next = STG_DEV;
        sub_next   = SP_IDLE;
        if (q_item.cmd == CMD_WRITE) begin
          is_read_next         = 1'b0;
          error_seen_next      = 1'b0;
          current_address_next = q_item.word_address;
          held_data_next       = q_item.write_data;
          bytes_left_next      = '0;
          o_busy = 1'b1;
          o_scl  = 1'b0;
          sub_next = SP_ST1;
        end else if (q_item.cmd == CMD_READ) begin
          is_read_next         = 1'b1;
          error_seen_next      = 1'b0;
          current_address_next = q_item.word_address;
          bytes_left_next      = q_item.byte_count;
          o_busy = 1'b1;
          if (!q_item.card_present) begin
            o_done   = 1'b1;
            o_status = STATUS_NO_CARD;
          end else if (q_item.byte_count == '0) begin
            o_done = 1'b1;
          end else begin
            o_scl    = 1'b0;
            sub_next = SP_ST1;
          end
        end
      end
      SP_ST0: begin
        o_scl    = 1'b0;
        sub_next = SP_ST1;
      end
      SP_ST1: begin
        if (!q_item.sda_in) begin
          fail_req = 1'b1;
        end else begin
          sub_next = SP_ST2;
        end
      end
      SP_ST2: begin
        o_sda = 1'b0;
        if (q_item.sda_in) begin
          fail_req = 1'b1;
        end else begin
          sub_next = SP_ST3;
        end
      end
      SP_ST3: begin
        o_scl    = 1'b0;
        o_sda    = 1'b0;
        load_req = 1'b1;
      end
      SP_WLO: begin
        o_scl    = 1'b0;
        o_sda    = shift_byte[BYTE_W-1];
        sub_next = SP_WHI;
      end
      SP_WHI: begin
        o_sda            = shift_byte[BYTE_W-1];
        shift_byte_next  = {shift_byte[BYTE_W-2:0], 1'b0};
        bit_counter_next = bit_counter + 4'd1;
        sub_next         = (bit_counter_next >= 4'd8) ? SP_ALO : SP_WLO;
      end
      SP_ALO: begin
        o_scl    = 1'b0;
        sub_next = SP_AHI;
      end
      SP_AHI: begin
        if (q_item.sda_in) begin
          error_seen_next = 1'b1;
          shift_byte_next = '0;
          sub_next        = SP_P1;
        end else if (stage == STG_DEV) begin
          load_req   = 1'b1;
          load_stage = STG_ADDR;
        end else if (stage == STG_ADDR) begin
          if (is_read) begin
            stage_next = STG_LAST;
            sub_next   = SP_ST0;
          end else begin
            load_req   = 1'b1;
            load_stage = STG_LAST;
          end
        end else if (stage == STG_LAST && is_read) begin
          shift_byte_next  = '0;
          bit_counter_next = '0;
          stage_next       = STG_RECV;
          sub_next         = SP_RLO;
        end else begin
          sub_next = SP_P1;
        end
      end
      SP_RLO: begin
        o_scl    = 1'b0;
        sub_next = SP_RHI;
      end
      SP_RHI: begin
        shift_byte_next  = {shift_byte[BYTE_W-2:0], q_item.sda_in};
        bit_counter_next = bit_counter + 4'd1;
        sub_next         = (bit_counter_next >= 4'd8) ? SP_NLO : SP_RLO;
      end
      SP_NLO: begin
        o_scl    = 1'b0;
        sub_next = SP_NHI;
      end
      SP_NHI: begin
        sub_next = SP_P1;
      end
      SP_P1: begin
        o_scl    = 1'b0;
        o_sda    = 1'b0;
        sub_next = SP_P2;
      end
      SP_P2: begin
        o_sda    = 1'b0;
        sub_next = SP_P3;
      end
      SP_P3: begin
        if (is_read) begin
          emit_req = 1'b1;
        end else begin
          finish_req = 1'b1;
        end
      end
      default: begin
        stage_next = STG_DEV;
        sub_next   = SP_IDLE;
      end
    endcase

    if (fail_req) begin
      error_seen_next = 1'b1;
      shift_byte_next = '0;
      if (stage == STG_LAST) begin
        sub_next = SP_P1;
      end else if (is_read) begin
        emit_req  = 1'b1;
        emit_data = '0;
      end else begin
        finish_req = 1'b1;
      end
    end

    if (load_req) begin
      case (load_stage)
        STG_DEV:  shift_byte_next = dev_byte;
        STG_ADDR: shift_byte_next = current_address;
        default:  shift_byte_next = is_read ? (dev_byte | 8'h01) : held_data;
      endcase
      bit_counter_next = '0;
      stage_next       = load_stage;
      sub_next         = SP_WLO;
    end

    if (emit_req) begin
      o_valid              = 1'b1;
      o_data               = emit_data;
      o_status             = error_seen_next ? STATUS_FAIL : STATUS_OK;
      current_address_next = current_address + 1'b1;
      bytes_left_next      = bytes_left - 1'b1;
      stage_next           = STG_DEV;
      if (bytes_left_next == '0) begin
        o_done   = 1'b1;
        sub_next = SP_IDLE;
      end else begin
        sub_next = SP_ST0;
      end
    end

    if (finish_req) begin
      o_done     = 1'b1;
      o_status   = error_seen_next ? STATUS_FAIL : STATUS_OK;
      stage_next = STG_DEV;
      sub_next   = SP_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage           <= STG_DEV;
      sub             <= SP_IDLE;
      bit_counter     <= '0;
      shift_byte      <= '0;
      current_address <= '0;
      bytes_left      <= '0;
      held_data       <= '0;
      error_seen      <= 1'b0;
      is_read         <= 1'b0;
    end else if (q_pop) begin
      stage           <= stage_next;
      sub             <= sub_next;
      bit_counter     <= bit_counter_next;
      shift_byte      <= shift_byte_next;
      current_address <= current_address_next;
      bytes_left      <= bytes_left_next;
      held_data       <= held_data_next;
      error_seen      <= error_seen_next;
      is_read         <= is_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      scl_level   <= o_scl;
      sda_release <= o_sda;
      busy_res    <= o_busy;
      byte_valid  <= o_valid;
      read_data   <= o_data;
      done_res    <= o_done;
      status      <= o_status;
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(sub) && $stable(bytes_left) && out_valid)
    else $error("engine advanced while result beat stalled");

  a_status_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> byte_valid || done_res)
    else $error("status set on a beat without byte or done");

  a_data_needs_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != '0) |-> byte_valid)
    else $error("read data set without byte valid");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_valid || done_res) |-> busy_res)
    else $error("byte or done beat reported while not busy");

  a_no_card_bus: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_NO_CARD) |-> scl_level && sda_release && !byte_valid)
    else $error("no-card beat touched the bus");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the serial EEPROM byte master
// Drives bus ticks with a responding slave whose SDA replies follow the
// expected bus phase, so that most writes and reads run to the end while a
// share of them fail their start or acknowledge. Every result beat is checked
// field by field against scripted lines or an in-bench model of the sequencer,
// across several device addresses and handshake idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import iebm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_TICKS = 350;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic [7:0] count;
    logic       card;
    logic       sda;
  } bus_tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda_rel;
    logic       busy;
    logic       bvalid;
    logic [7:0] rdata;
    logic       done;
    logic [1:0] stat;
  } line_state_t;

  typedef struct packed {
    bus_tick_t   tick;
    logic        typed;
    line_state_t want;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] operation = '0;
  logic [7:0] word_address = '0;
  logic [7:0] write_data = '0;
  logic [7:0] byte_count = '0;
  logic       card_present = 1'b0;
  logic       sda_in = 1'b1;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       byte_valid;
  logic [7:0] read_data;
  logic       done_res;
  logic [1:0] status;

  i2c_eeprom_byte_master uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .word_address (word_address),
    .write_data   (write_data),
    .byte_count   (byte_count),
    .card_present (card_present),
    .sda_in       (sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_level    (scl_level),
    .sda_release  (sda_release),
    .busy_res     (busy_res),
    .byte_valid   (byte_valid),
    .read_data    (read_data),
    .done_res     (done_res),
    .status       (status)
  );

  always #6 clk = ~clk;

  // sequencer model state
  logic [6:0] ee_dev = 7'd80;
  sub_t       ee_sub = SP_IDLE;
  stage_t     ee_stage = STG_DEV;
  logic [3:0] ee_bits = '0;
  logic [7:0] ee_shift = '0;
  logic [7:0] ee_addr = '0;
  logic [7:0] ee_left = '0;
  logic [7:0] ee_held = '0;
  logic       ee_err = 1'b0;
  logic       ee_rd = 1'b0;

  line_state_t expected_lines[$];
  bit noisy_txn;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatches = 0;
  int beats_seen = 0;
  int live_ticks = 0;
  int cfg_writes = 0;
  int writes_ended = 0;
  int read_bytes = 0;
  int failed_ends = 0;
  int nocard_ends = 0;

  function automatic void ee_load(input stage_t st);
    logic [7:0] dev_byte;
    dev_byte = {ee_dev, 1'b0};
    case (st)
      STG_DEV:  ee_shift = dev_byte;
      STG_ADDR: ee_shift = ee_addr;
      default:  ee_shift = ee_rd ? {ee_dev, 1'b1} : ee_held;
    endcase
    ee_bits = '0;
    ee_stage = st;
    ee_sub = SP_WLO;
  endfunction

  function automatic void ee_emit_byte(inout line_state_t r);
    r.bvalid = 1'b1;
    r.rdata = ee_shift;
    r.stat = ee_err ? STATUS_FAIL : STATUS_OK;
    ee_addr = ee_addr + 8'd1;
    ee_left = ee_left - 8'd1;
    ee_stage = STG_DEV;
    if (ee_left == 8'd0) begin
      r.done = 1'b1;
      ee_sub = SP_IDLE;
    end else begin
      ee_sub = SP_ST0;
    end
  endfunction

  function automatic void ee_finish_write(inout line_state_t r);
    r.done = 1'b1;
    r.stat = ee_err ? STATUS_FAIL : STATUS_OK;
    ee_stage = STG_DEV;
    ee_sub = SP_IDLE;
  endfunction

  function automatic void ee_start_failed(inout line_state_t r);
    ee_err = 1'b1;
    ee_shift = '0;
    if (ee_stage == STG_LAST) ee_sub = SP_P1;
    else if (ee_rd) ee_emit_byte(r);
    else ee_finish_write(r);
  endfunction

  function automatic line_state_t ee_step(input bus_tick_t t);
    line_state_t r;
    r = '0;
    r.scl = 1'b1;
    r.sda_rel = 1'b1;
    if (ee_sub != SP_IDLE) r.busy = 1'b1;
    case (ee_sub)
      SP_IDLE: begin
        ee_stage = STG_DEV;
        if (t.op == OP_WRITE) begin
          ee_rd = 1'b0;
          ee_err = 1'b0;
          ee_addr = t.addr;
          ee_held = t.wdata;
          ee_left = '0;
          r.busy = 1'b1;
          r.scl = 1'b0;
          ee_sub = SP_ST1;
        end else if (t.op == OP_READ) begin
          ee_rd = 1'b1;
          ee_err = 1'b0;
          ee_addr = t.addr;
          ee_left = t.count;
          r.busy = 1'b1;
          if (!t.card) begin
            r.done = 1'b1;
            r.stat = STATUS_NO_CARD;
          end else if (t.count == 8'd0) begin
            r.done = 1'b1;
          end else begin
            r.scl = 1'b0;
            ee_sub = SP_ST1;
          end
        end
      end
      SP_ST0: begin
        r.scl = 1'b0;
        ee_sub = SP_ST1;
      end
      SP_ST1: begin
        if (!t.sda) ee_start_failed(r);
        else ee_sub = SP_ST2;
      end
      SP_ST2: begin
        r.sda_rel = 1'b0;
        if (t.sda) ee_start_failed(r);
        else ee_sub = SP_ST3;
      end
      SP_ST3: begin
        r.scl = 1'b0;
        r.sda_rel = 1'b0;
        ee_load(ee_stage);
      end
      SP_WLO: begin
        r.scl = 1'b0;
        r.sda_rel = ee_shift[7];
        ee_sub = SP_WHI;
      end
      SP_WHI: begin
        r.sda_rel = ee_shift[7];
        ee_shift = {ee_shift[6:0], 1'b0};
        ee_bits = ee_bits + 4'd1;
        ee_sub = (ee_bits >= 4'd8) ? SP_ALO : SP_WLO;
      end
      SP_ALO: begin
        r.scl = 1'b0;
        ee_sub = SP_AHI;
      end
      SP_AHI: begin
        if (t.sda) begin
          ee_err = 1'b1;
          ee_shift = '0;
          ee_sub = SP_P1;
        end else if (ee_stage == STG_DEV) begin
          ee_load(STG_ADDR);
        end else if (ee_stage == STG_ADDR) begin
          if (ee_rd) begin
            ee_stage = STG_LAST;
            ee_sub = SP_ST0;
          end else begin
            ee_load(STG_LAST);
          end
        end else if (ee_stage == STG_LAST && ee_rd) begin
          ee_shift = '0;
          ee_bits = '0;
          ee_stage = STG_RECV;
          ee_sub = SP_RLO;
        end else begin
          ee_sub = SP_P1;
        end
      end
      SP_RLO: begin
        r.scl = 1'b0;
        ee_sub = SP_RHI;
      end
      SP_RHI: begin
        ee_shift = {ee_shift[6:0], t.sda};
        ee_bits = ee_bits + 4'd1;
        ee_sub = (ee_bits >= 4'd8) ? SP_NLO : SP_RLO;
      end
      SP_NLO: begin
        r.scl = 1'b0;
        ee_sub = SP_NHI;
      end
      SP_NHI: ee_sub = SP_P1;
      SP_P1: begin
        r.scl = 1'b0;
        r.sda_rel = 1'b0;
        ee_sub = SP_P2;
      end
      SP_P2: begin
        r.sda_rel = 1'b0;
        ee_sub = SP_P3;
      end
      default: begin
        if (ee_rd) ee_emit_byte(r);
        else ee_finish_write(r);
      end
    endcase
    return r;
  endfunction

  // slave side: answer starts and acks as a healthy part would, with rare slips
  function automatic bus_tick_t next_tick();
    bus_tick_t t;
    bit flip;
    t.op = 2'($urandom_range(3));
    t.addr = 8'($urandom);
    t.wdata = 8'($urandom);
    t.count = 8'($urandom);
    t.card = 1'($urandom);
    t.sda = 1'($urandom);
    flip = ($urandom_range(99) < 2);
    if (ee_sub == SP_IDLE) begin
      noisy_txn = ($urandom_range(99) < 12);
      if ($urandom_range(99) < 80) begin
        t.op = ($urandom_range(9) < 4) ? OP_WRITE : OP_READ;
        if ($urandom_range(7) == 0) t.addr = ($urandom_range(1) != 0) ? 8'hFF : 8'hFE;
        t.card = ($urandom_range(19) != 0);
        if (t.card) t.count = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(3, 1));
      end else begin
        t.op = ($urandom_range(1) != 0) ? OP_UNUSED : OP_TICK;
      end
    end else if (!noisy_txn) begin
      case (ee_sub)
        SP_ST1:         t.sda = !flip;
        SP_ST2, SP_AHI: t.sda = flip;
        default: ;
      endcase
    end
    return t;
  endfunction

  function automatic bus_tick_t tick_of(input logic [1:0] op, input logic [7:0] addr,
                                        input logic [7:0] wdata, input logic [7:0] count,
                                        input logic card, input logic sda);
    bus_tick_t t;
    t = '{op: op, addr: addr, wdata: wdata, count: count, card: card, sda: sda};
    return t;
  endfunction

  function automatic line_state_t want_line(input logic scl, input logic sda_rel,
                                            input logic busy, input logic bvalid,
                                            input logic [7:0] rdata, input logic done,
                                            input logic [1:0] stat);
    line_state_t r;
    r = '{scl: scl, sda_rel: sda_rel, busy: busy, bvalid: bvalid, rdata: rdata,
          done: done, stat: stat};
    return r;
  endfunction

  task automatic send_tick(input bus_tick_t t, input logic typed, input line_state_t want);
    line_state_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= t.op;
    word_address <= t.addr;
    write_data <= t.wdata;
    byte_count <= t.count;
    card_present <= t.card;
    sda_in <= t.sda;
    do @(posedge clk); while (in_stall);
    if (ee_sub != SP_IDLE || t.op == OP_WRITE || t.op == OP_READ) live_ticks++;
    pred = ee_step(t);
    if (pred.bvalid) read_bytes++;
    if (pred.done && !ee_rd) writes_ended++;
    if ((pred.done || pred.bvalid) && pred.stat == STATUS_FAIL) failed_ends++;
    if (pred.done && pred.stat == STATUS_NO_CARD) nocard_ends++;
    expected_lines.push_back(typed ? want : pred);
  endtask

  task automatic finish_txn();
    while (ee_sub != SP_IDLE) send_tick(next_tick(), 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_device(input logic [6:0] dev);
    cfg_valid <= 1'b1;
    cfg_data <= dev;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ee_dev = dev;
    cfg_writes++;
  endtask

  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want_v);
    mismatches++;
    if (mismatches <= 20)
      $display("mismatch at beat %0d: %s got %0h want %0h", beats_seen, what, got, want_v);
  endtask

  task automatic check_beat();
    line_state_t want;
    if (expected_lines.size() == 0) begin
      note_mismatch("beat with nothing pending", 8'd1, 8'd0);
      return;
    end
    want = expected_lines.pop_front();
    if (scl_level !== want.scl) note_mismatch("scl_level", 8'(scl_level), 8'(want.scl));
    if (sda_release !== want.sda_rel)
      note_mismatch("sda_release", 8'(sda_release), 8'(want.sda_rel));
    if (busy_res !== want.busy) note_mismatch("busy_res", 8'(busy_res), 8'(want.busy));
    if (byte_valid !== want.bvalid) note_mismatch("byte_valid", 8'(byte_valid), 8'(want.bvalid));
    if (read_data !== want.rdata) note_mismatch("read_data", read_data, want.rdata);
    if (done_res !== want.done) note_mismatch("done_res", 8'(done_res), 8'(want.done));
    if (status !== want.stat) note_mismatch("status", 8'(status), 8'(want.stat));
    beats_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_beat();
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    script_row_t rows[$];
    int start_count;
    logic [6:0] dev;
    int idle;
    int stall;
    bit paused;

    rows.push_back('{tick_of(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
                     want_line(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    rows.push_back('{tick_of(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1), 1'b1,
                     want_line(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    rows.push_back('{tick_of(OP_READ, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1), 1'b1,
                     want_line(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, STATUS_NO_CARD)});
    rows.push_back('{tick_of(OP_READ, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0), 1'b1,
                     want_line(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, STATUS_OK)});
    rows.push_back('{tick_of(OP_WRITE, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1), 1'b1,
                     want_line(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    rows.push_back('{tick_of(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
                     want_line(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, STATUS_FAIL)});
    rows.push_back('{tick_of(OP_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0), 1'b1,
                     want_line(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    rows.push_back('{tick_of(OP_READ, 8'h00, 8'h00, 8'h01, 1'b1, 1'b1), 1'b1,
                     want_line(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    rows.push_back('{tick_of(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1), 1'b1,
                     want_line(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1, STATUS_FAIL)});
    rows.push_back('{tick_of(OP_READ, 8'hFF, 8'h00, 8'h01, 1'b1, 1'b0), 1'b1,
                     want_line(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    rows.push_back('{tick_of(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0), 1'b1,
                     want_line(1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, STATUS_FAIL)});
    rows.push_back('{tick_of(OP_READ, 8'hFF, 8'h00, 8'h02, 1'b1, 1'b1), 1'b1,
                     want_line(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    rows.push_back('{tick_of(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0), 1'b1,
                     want_line(1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, STATUS_FAIL)});
    rows.push_back('{tick_of(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0), 1'b1,
                     want_line(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    rows.push_back('{tick_of(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1), 1'b1,
                     want_line(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    rows.push_back('{tick_of(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0), 1'b1,
                     want_line(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    rows.push_back('{tick_of(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0), 1'b1,
                     want_line(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, STATUS_OK)});
    for (int i = 0; i < 8; i++)
      rows.push_back('{tick_of(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0), 1'b0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_tick(rows[i].tick, rows[i].typed, rows[i].want);
    finish_txn();
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin dev = 7'd0; idle = 0; stall = 0; end
        1: begin dev = 7'h7F; idle = 50; stall = 0; end
        2: begin dev = 7'($urandom); idle = 0; stall = 50; end
        3: begin dev = 7'($urandom); idle = 20; stall = 20; end
        default: begin dev = 7'($urandom); idle = 0; stall = 0; end
      endcase
      set_device(dev);
      send_idle_pct = idle;
      stall_pct = stall;
      if (p == 2 || p == 4) hold_req <= hold_req + 1;
      paused = 1'b0;
      start_count = live_ticks;
      while (live_ticks - start_count < PHASE_TICKS) begin
        if (p == 4 && !paused && live_ticks - start_count >= PHASE_TICKS / 2) begin
          paused = 1'b1;
          wait_drained();
        end
        send_tick(next_tick(), 1'b0, '0);
      end
      finish_txn();
      wait_drained();
    end

    if (expected_lines.size() != 0)
      note_mismatch("results never seen", 8'(expected_lines.size()), 8'd0);
    $display("covered %0d live ticks and %0d checked beats over %0d device addresses",
             live_ticks, beats_seen, cfg_writes + 1);
    $display("bus outcomes: %0d writes ended, %0d read bytes, %0d failures, %0d no-card",
             writes_ended, read_bytes, failed_ends, nocard_ends);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
